/* hw/rtl/dotted_label_name_validator_unit_defines.svh */
// ----------------------------------------------------------------------------
// Dotted label name validator - assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DOTTED_LABEL_NAME_VALIDATOR_UNIT_DEFINES_SVH
`define DOTTED_LABEL_NAME_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define DLNV_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dlnv: same-cycle check failed");

`define DLNV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dlnv: next-cycle check failed");

`else

`define DLNV_ASSERT_SAME(label, clk, rstn, ante, cons)

`define DLNV_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/dlnv_pkg.sv */
// ----------------------------------------------------------------------------
// dlnv_pkg
// Shared types and constants of the dotted label name validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dlnv_pkg;

    localparam int unsigned COUNT_LIMIT_DEF = 255;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned MIN_LEN_W  = 6;
    localparam int unsigned MAX_LEN_W  = 8;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned LEN_OUT_W  = 8;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 16;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 6'd3;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 8'd63;

    localparam logic [CH_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [CH_W-1:0] CHAR_0      = 8'h30;
    localparam logic [CH_W-1:0] CHAR_9      = 8'h39;
    localparam logic [CH_W-1:0] CASE_BIT    = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_LEN = 1'b0,
        REG_MAX_LEN = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        CL_LETTER = 2'd0,
        CL_DIGIT  = 2'd1,
        CL_HYPHEN = 2'd2,
        CL_OTHER  = 2'd3
    } char_class_t;

    typedef enum logic [2:0] {
        FAULT_OK          = 3'd0,
        FAULT_TOO_SHORT   = 3'd1,
        FAULT_TOO_LONG    = 3'd2,
        FAULT_LABEL_SHORT = 3'd3,
        FAULT_BAD_FIRST   = 3'd4,
        FAULT_BAD_LAST    = 3'd5,
        FAULT_BAD_MIDDLE  = 3'd6
    } fault_t;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] name_length;
        fault_t               fault;
        logic                 valid_res;
    } result_t;

    typedef struct packed {
        logic        is_dot;
        char_class_t cls;
    } char_info_t;

endpackage

`default_nettype wire

/* hw/rtl/dotted_label_name_validator_unit.sv */
// ----------------------------------------------------------------------------
// dotted_label_name_validator_unit
// Checks a dotted name streamed one byte per request and returns one verdict
// per name.
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata = ch, s_tlast = is_last
// m_        out  m_tvalid/m_tready    m_tdata = valid_res, fault, name_length
// cfg_      in   cfg_we               cfg_index, cfg_wdata
//
// One byte per cycle sustained while no last byte waits on an unread verdict;
// bytes pass the input register; a last byte's verdict goes to the result register.
// Bytes that are not last never wait on the result side.
// A last byte holds in the input register while a verdict stalls unread.
// Reset clears all counters and restores min_len 3 and max_len 63.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dotted_label_name_validator_unit_defines.svh"

module dotted_label_name_validator_unit #(
    parameter int unsigned COUNT_LIMIT = dlnv_pkg::COUNT_LIMIT_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [dlnv_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] ch
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [dlnv_pkg::M_TDATA_W-1:0]          m_tdata,  // [0] valid_res,
                                                              // [3:1] fault,
                                                              // [11:4] name_length
    input  wire logic                               cfg_we,
    input  wire logic [dlnv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dlnv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic                                in_valid_reg;
    logic [dlnv_pkg::CH_W-1:0]           in_ch_reg;
    logic                                in_last_reg;
    logic                                out_valid_reg;
    dlnv_pkg::result_t                   out_res_reg;
    logic [dlnv_pkg::MIN_LEN_W-1:0]      min_len_reg;
    logic [dlnv_pkg::MAX_LEN_W-1:0]      max_len_reg;

    logic                                advance;
    logic                                out_free;
    dlnv_pkg::char_info_t                info;
    dlnv_pkg::result_t                   result;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dlnv_pkg::M_TDATA_W - $bits(dlnv_pkg::result_t)){1'b0}}, out_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= dlnv_pkg::MIN_LEN_RST;
            max_len_reg <= dlnv_pkg::MAX_LEN_RST;
        end else if (cfg_we) begin
            unique case (dlnv_pkg::reg_idx_t'(cfg_index))
                dlnv_pkg::REG_MIN_LEN: min_len_reg <= cfg_wdata[dlnv_pkg::MIN_LEN_W-1:0];
                dlnv_pkg::REG_MAX_LEN: max_len_reg <= cfg_wdata[dlnv_pkg::MAX_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg   <= s_tdata[dlnv_pkg::CH_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_res_reg <= result;
        end
    end

    dlnv_class u_class (
        .ch   (in_ch_reg),
        .info (info)
    );

    dlnv_state #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .min_len (min_len_reg),
        .max_len (max_len_reg),
        .advance (advance),
        .last    (in_last_reg),
        .info    (info),
        .result  (result)
    );

    `DLNV_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, advance && in_last_reg, out_valid_reg)
    `DLNV_ASSERT_NEXT(a_stalled_byte_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_ch_reg) && $stable(in_last_reg))
    `DLNV_ASSERT_SAME(a_verdict_matches_fault, aclk, aresetn, out_valid_reg, out_res_reg.valid_res == (out_res_reg.fault == dlnv_pkg::FAULT_OK))
    `DLNV_ASSERT_SAME(a_nonlast_never_waits, aclk, aresetn, in_valid_reg && !in_last_reg, advance)

endmodule

`default_nettype wire

/* hw/rtl/dlnv_class.sv */
// ----------------------------------------------------------------------------
// dlnv_class
// Folds one byte to lower case and sorts it into dot, letter, digit,
// hyphen or other.
// ----------------------------------------------------------------------------
`default_nettype none

module dlnv_class (
    input  wire logic [dlnv_pkg::CH_W-1:0] ch,
    output dlnv_pkg::char_info_t           info
);

    logic [dlnv_pkg::CH_W-1:0] folded;

    always_comb begin
        if (ch >= dlnv_pkg::CHAR_UP_A && ch <= dlnv_pkg::CHAR_UP_Z) begin
            folded = ch | dlnv_pkg::CASE_BIT;
        end else begin
            folded = ch;
        end
        info.is_dot = (folded == dlnv_pkg::CHAR_DOT);
        if (folded >= dlnv_pkg::CHAR_LO_A && folded <= dlnv_pkg::CHAR_LO_Z) begin
            info.cls = dlnv_pkg::CL_LETTER;
        end else if (folded >= dlnv_pkg::CHAR_0 && folded <= dlnv_pkg::CHAR_9) begin
            info.cls = dlnv_pkg::CL_DIGIT;
        end else if (folded == dlnv_pkg::CHAR_HYPHEN) begin
            info.cls = dlnv_pkg::CL_HYPHEN;
        end else begin
            info.cls = dlnv_pkg::CL_OTHER;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dlnv_state.sv */
// ----------------------------------------------------------------------------
// dlnv_state
// Per-name counters and label flags; closes labels and forms the verdict
// on the last byte of a name.
// ----------------------------------------------------------------------------
`default_nettype none

module dlnv_state #(
    parameter int unsigned COUNT_LIMIT = dlnv_pkg::COUNT_LIMIT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [dlnv_pkg::MIN_LEN_W-1:0]      min_len,
    input  wire logic [dlnv_pkg::MAX_LEN_W-1:0]      max_len,
    input  wire logic                                advance,
    input  wire logic                                last,
    input  wire dlnv_pkg::char_info_t                info,
    output dlnv_pkg::result_t                        result
);

    localparam int unsigned CNT_W = $clog2(COUNT_LIMIT + 1);
    localparam int unsigned CMP_W = (CNT_W > dlnv_pkg::MAX_LEN_W) ? CNT_W
                                                                   : dlnv_pkg::MAX_LEN_W;
    localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(COUNT_LIMIT);
    localparam logic [CMP_W-1:0] LEN_CLIP = CMP_W'((1 << dlnv_pkg::LEN_OUT_W) - 1);

    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      label_reg, label_next;
    dlnv_pkg::char_class_t prev_reg, prev_next;
    logic                  first_bad_reg, first_bad_next;
    logic                  middle_bad_reg, middle_bad_next;
    dlnv_pkg::fault_t      ffault_reg, ffault_next;

    logic [CNT_W-1:0]      lab_upd;
    dlnv_pkg::char_class_t prev_upd;
    logic                  first_upd;
    logic                  middle_upd;
    dlnv_pkg::fault_t      code_dot;
    dlnv_pkg::fault_t      code_last;
    dlnv_pkg::fault_t      ff_mid;
    dlnv_pkg::fault_t      ff_end;
    dlnv_pkg::fault_t      verdict;
    logic [CMP_W-1:0]      total_ext;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v >= LIMIT) ? LIMIT : v + 1'b1;
    endfunction

    function automatic dlnv_pkg::fault_t close_code(
        input logic [CNT_W-1:0]              cnt,
        input logic                          fbad,
        input dlnv_pkg::char_class_t         pcls,
        input logic                          mbad,
        input logic [dlnv_pkg::MIN_LEN_W-1:0] mlen
    );
        if (cnt < CNT_W'(mlen)) begin
            close_code = dlnv_pkg::FAULT_LABEL_SHORT;
        end else if (cnt == '0 || fbad) begin
            close_code = dlnv_pkg::FAULT_BAD_FIRST;
        end else if (pcls != dlnv_pkg::CL_LETTER && pcls != dlnv_pkg::CL_DIGIT) begin
            close_code = dlnv_pkg::FAULT_BAD_LAST;
        end else if (mbad) begin
            close_code = dlnv_pkg::FAULT_BAD_MIDDLE;
        end else begin
            close_code = dlnv_pkg::FAULT_OK;
        end
    endfunction

    always_comb begin
        total_next = sat_inc(total_reg);
        code_dot   = close_code(label_reg, first_bad_reg, prev_reg, middle_bad_reg, min_len);

        if (info.is_dot) begin
            lab_upd    = '0;
            prev_upd   = dlnv_pkg::CL_LETTER;
            first_upd  = 1'b0;
            middle_upd = 1'b0;
            ff_mid     = (ffault_reg == dlnv_pkg::FAULT_OK) ? code_dot : ffault_reg;
        end else begin
            lab_upd    = sat_inc(label_reg);
            prev_upd   = info.cls;
            first_upd  = first_bad_reg;
            middle_upd = middle_bad_reg;
            ff_mid     = ffault_reg;
            if (label_reg == '0) begin
                first_upd = (info.cls != dlnv_pkg::CL_LETTER);
            end else if (label_reg >= CNT_W'(2) && prev_reg == dlnv_pkg::CL_OTHER) begin
                middle_upd = 1'b1;
            end
        end

        code_last = close_code(lab_upd, first_upd, prev_upd, middle_upd, min_len);
        ff_end    = (ff_mid == dlnv_pkg::FAULT_OK) ? code_last : ff_mid;

        total_ext = CMP_W'(total_next);
        if (total_ext < CMP_W'(min_len)) begin
            verdict = dlnv_pkg::FAULT_TOO_SHORT;
        end else if (total_ext > CMP_W'(max_len)) begin
            verdict = dlnv_pkg::FAULT_TOO_LONG;
        end else begin
            verdict = ff_end;
        end

        result.fault       = verdict;
        result.valid_res   = (verdict == dlnv_pkg::FAULT_OK);
        result.name_length = (total_ext > LEN_CLIP) ? LEN_CLIP[dlnv_pkg::LEN_OUT_W-1:0]
                                                    : total_ext[dlnv_pkg::LEN_OUT_W-1:0];

        if (last) begin
            total_next      = '0;
            label_next      = '0;
            prev_next       = dlnv_pkg::CL_LETTER;
            first_bad_next  = 1'b0;
            middle_bad_next = 1'b0;
            ffault_next     = dlnv_pkg::FAULT_OK;
        end else begin
            label_next      = lab_upd;
            prev_next       = prev_upd;
            first_bad_next  = first_upd;
            middle_bad_next = middle_upd;
            ffault_next     = ff_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= '0;
            label_reg      <= '0;
            prev_reg       <= dlnv_pkg::CL_LETTER;
            first_bad_reg  <= 1'b0;
            middle_bad_reg <= 1'b0;
            ffault_reg     <= dlnv_pkg::FAULT_OK;
        end else if (advance) begin
            total_reg      <= total_next;
            label_reg      <= label_next;
            prev_reg       <= prev_next;
            first_bad_reg  <= first_bad_next;
            middle_bad_reg <= middle_bad_next;
            ffault_reg     <= ffault_next;
        end
    end

endmodule

`default_nettype wire

/* test/dotted_label_name_validator_unit_test.sv */
// ----------------------------------------------------------------------------
// dotted_label_name_validator_unit_test
// Streams dotted names into the validator byte by byte and checks each
// verdict against a cycle-free predictor of the label rules. A short directed
// part covers the rule faults, case folding, empty labels and extreme bytes.
// Random names follow under several min/max length settings and long
// saturating names, with bursty input, random output stalls and one long
// output hold-off that fills the block.
// ----------------------------------------------------------------------------
module dotted_label_name_validator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 4;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int SETTLE      = 6;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_BURSTY,
        RX_HOLD
    } rx_mode_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [dlnv_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] ch
    logic                            s_tlast   = 1'b0; // is_last
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [dlnv_pkg::M_TDATA_W-1:0]  m_tdata;          // [0] valid_res, [3:1] fault,
                                                       // [11:4] name_length
    logic                            cfg_we    = 1'b0;
    logic [dlnv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dlnv_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    dotted_label_name_validator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #HALF_PERIOD;
        aclk = 1'b0;
        #HALF_PERIOD;
    end

    // Predictor state
    logic [dlnv_pkg::MIN_LEN_W-1:0] cur_min     = dlnv_pkg::MIN_LEN_RST;
    logic [dlnv_pkg::MAX_LEN_W-1:0] cur_max     = dlnv_pkg::MAX_LEN_RST;
    logic [7:0]                     name_bytes  = '0;
    logic [7:0]                     label_bytes = '0;
    dlnv_pkg::char_class_t          last_cls    = dlnv_pkg::CL_LETTER;
    logic                           lead_bad    = 1'b0;
    logic                           inner_bad   = 1'b0;
    dlnv_pkg::fault_t               label_fault = dlnv_pkg::FAULT_OK;

    dlnv_pkg::result_t verdict_q[$];
    logic [7:0]        name_buf[$];

    rx_mode_t rx_mode    = RX_OPEN;
    bit       tx_gaps    = 1'b0;
    int       burst_left = 0;
    int       hold_cnt   = 0;
    int       stall_left = 0;
    int       idle_cycles = 0;

    int error_count     = 0;
    int verdicts_seen   = 0;
    int names_sent      = 0;
    int bytes_sent      = 0;
    int settings_used   = 1;

    function automatic dlnv_pkg::char_class_t class_of(input logic [7:0] c);
        if (c >= dlnv_pkg::CHAR_LO_A && c <= dlnv_pkg::CHAR_LO_Z)
            return dlnv_pkg::CL_LETTER;
        if (c >= dlnv_pkg::CHAR_0 && c <= dlnv_pkg::CHAR_9)
            return dlnv_pkg::CL_DIGIT;
        if (c == dlnv_pkg::CHAR_HYPHEN)
            return dlnv_pkg::CL_HYPHEN;
        return dlnv_pkg::CL_OTHER;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'(dlnv_pkg::COUNT_LIMIT_DEF)) ? v : v + 8'd1;
    endfunction

    function automatic void end_label();
        dlnv_pkg::fault_t code;
        code = dlnv_pkg::FAULT_OK;
        if (label_bytes < {2'b00, cur_min})
            code = dlnv_pkg::FAULT_LABEL_SHORT;
        else if (label_bytes == 8'd0 || lead_bad)
            code = dlnv_pkg::FAULT_BAD_FIRST;
        else if (last_cls != dlnv_pkg::CL_LETTER && last_cls != dlnv_pkg::CL_DIGIT)
            code = dlnv_pkg::FAULT_BAD_LAST;
        else if (inner_bad)
            code = dlnv_pkg::FAULT_BAD_MIDDLE;
        if (label_fault == dlnv_pkg::FAULT_OK)
            label_fault = code;
        label_bytes = '0;
        last_cls    = dlnv_pkg::CL_LETTER;
        lead_bad    = 1'b0;
        inner_bad   = 1'b0;
    endfunction

    function automatic void predict_byte(input logic [7:0] raw, input logic last);
        logic [7:0]            c;
        dlnv_pkg::char_class_t cls;
        dlnv_pkg::fault_t      verdict;
        dlnv_pkg::result_t     r;
        c = raw;
        if (c >= dlnv_pkg::CHAR_UP_A && c <= dlnv_pkg::CHAR_UP_Z)
            c = c | dlnv_pkg::CASE_BIT;
        name_bytes = bump(name_bytes);
        if (c == dlnv_pkg::CHAR_DOT) begin
            end_label();
        end else begin
            cls = class_of(c);
            if (label_bytes == 8'd0)
                lead_bad = (cls != dlnv_pkg::CL_LETTER);
            else if (label_bytes >= 8'd2 && last_cls == dlnv_pkg::CL_OTHER)
                inner_bad = 1'b1;
            last_cls    = cls;
            label_bytes = bump(label_bytes);
        end
        if (last) begin
            end_label();
            if (name_bytes < {2'b00, cur_min})
                verdict = dlnv_pkg::FAULT_TOO_SHORT;
            else if (name_bytes > cur_max)
                verdict = dlnv_pkg::FAULT_TOO_LONG;
            else
                verdict = label_fault;
            r.valid_res   = (verdict == dlnv_pkg::FAULT_OK);
            r.fault       = verdict;
            r.name_length = name_bytes;
            verdict_q.push_back(r);
            name_bytes  = '0;
            label_fault = dlnv_pkg::FAULT_OK;
        end
    endfunction

    // Receiver stall pattern
    always @(posedge aclk) begin
        if (rx_mode == RX_HOLD) begin
            if (hold_cnt < HOLD_CYCLES) begin
                m_tready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
            end else begin
                m_tready <= 1'b1;
            end
        end else begin
            hold_cnt <= 0;
            case (rx_mode)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_tready <= ($urandom_range(3) != 0);
                end
                default: begin
                    if (stall_left == 0) begin
                        m_tready   <= ~m_tready;
                        stall_left <= $urandom_range(1, 15);
                    end else begin
                        stall_left <= stall_left - 1;
                    end
                end
            endcase
        end
    end

    // Verdict checker and watchdog
    always @(posedge aclk) begin
        dlnv_pkg::result_t seen;
        dlnv_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = dlnv_pkg::result_t'(m_tdata[11:0]);
            if (verdict_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected verdict, expected none, actual %h", $time, m_tdata);
            end else begin
                want = verdict_q.pop_front();
                verdicts_seen++;
                if (seen.valid_res !== want.valid_res) begin
                    error_count++;
                    $display("%0t: valid_res expected %0b actual %0b",
                             $time, want.valid_res, seen.valid_res);
                end
                if (seen.fault !== want.fault) begin
                    error_count++;
                    $display("%0t: fault expected %0d actual %0d",
                             $time, want.fault, seen.fault);
                end
                if (seen.name_length !== want.name_length) begin
                    error_count++;
                    $display("%0t: name_length expected %0d actual %0d",
                             $time, want.name_length, seen.name_length);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_byte(c, last);
        bytes_sent++;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_name();
        int n;
        n = name_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(name_buf[i], i == n - 1);
        names_sent++;
        name_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [dlnv_pkg::MIN_LEN_W-1:0] lo,
                              input logic [dlnv_pkg::MAX_LEN_W-1:0] hi);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= dlnv_pkg::REG_MIN_LEN;
        cfg_wdata <= {2'($urandom_range(3)), lo};
        @(posedge aclk);
        cfg_index <= dlnv_pkg::REG_MAX_LEN;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_min = lo;
        cur_max = hi;
        settings_used++;
    endtask

    function automatic logic [7:0] label_char(input bit lead, input bit tail);
        int r;
        if (lead)
            r = $urandom_range(25);
        else if (tail)
            r = $urandom_range(35);
        else
            r = $urandom_range(36);
        if (r < 26)
            return (($urandom_range(3) == 0) ? dlnv_pkg::CHAR_UP_A : dlnv_pkg::CHAR_LO_A)
                   + 8'(r);
        if (r < 36)
            return dlnv_pkg::CHAR_0 + 8'(r - 26);
        return dlnv_pkg::CHAR_HYPHEN;
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(4))
            0:       return 8'($urandom);
            1:       return dlnv_pkg::CHAR_HYPHEN;
            2:       return dlnv_pkg::CHAR_DOT;
            3:       return dlnv_pkg::CHAR_0 + 8'($urandom_range(9));
            default: return 8'h80 | 8'($urandom);
        endcase
    endfunction

    task automatic make_name();
        int nlab;
        int len;
        int pick;
        name_buf.delete();
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 10);
            repeat (len) name_buf.push_back(8'($urandom));
        end else begin
            nlab = $urandom_range(1, 3);
            for (int l = 0; l < nlab; l++) begin
                if (l > 0)
                    name_buf.push_back(dlnv_pkg::CHAR_DOT);
                pick = $urandom_range(19);
                if (pick == 0)
                    len = 0;
                else if (pick == 1)
                    len = int'(cur_min) - 1;
                else
                    len = int'(cur_min) + $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    name_buf.push_back(label_char(i == 0, i == len - 1));
            end
            if ($urandom_range(19) == 0)
                name_buf.push_back(dlnv_pkg::CHAR_DOT);
            if ($urandom_range(3) == 0 && name_buf.size() > 0)
                name_buf[$urandom_range(name_buf.size() - 1)] = odd_char();
        end
        if (name_buf.size() == 0)
            name_buf.push_back(dlnv_pkg::CHAR_LO_A);
    endtask

    task automatic test_reset_values();
        tx_gaps = 1'b0;
        rx_mode <= RX_OPEN;
        put_text("ab");
        send_name();
        put_text("Abc");
        send_name();
    endtask

    task automatic test_label_faults();
        set_limits(6'd1, 8'd4);
        put_text("A");
        send_name();
        put_text(".");
        send_name();
        put_text("a..b");
        send_name();
        put_text("abcde");
        send_name();
        put_text("1b");
        send_name();
        put_text("b-");
        send_name();
        put_text("a");
        name_buf.push_back(8'hFF);
        put_text("z");
        send_name();
        name_buf.push_back(8'h00);
        send_name();
    endtask

    task automatic test_random_names();
        int lo_tab[7]     = '{1, 3, 63, 1, 63, 2, 0};
        int hi_tab[7]     = '{254, 63, 254, 1, 63, 12, 0};
        int budget_tab[7] = '{150, 150, 200, 60, 100, 150, 140};
        int sent;
        for (int p = 0; p < 7; p++) begin
            if (p == 6) begin
                lo_tab[p] = $urandom_range(1, 8);
                hi_tab[p] = $urandom_range(lo_tab[p] + 4, 80);
            end
            set_limits(6'(lo_tab[p]), 8'(hi_tab[p]));
            tx_gaps = (p % 2 == 0);
            rx_mode <= rx_mode_t'(p % 3);
            sent = 0;
            while (sent < budget_tab[p]) begin
                make_name();
                sent += name_buf.size();
                send_name();
            end
        end
    endtask

    task automatic test_long_names();
        int len_tab[3] = '{254, 255, 300};
        set_limits(6'd1, 8'd254);
        tx_gaps = 1'b1;
        rx_mode <= RX_BURSTY;
        foreach (len_tab[k]) begin
            for (int i = 0; i < len_tab[k]; i++)
                name_buf.push_back(label_char(i == 0, i == len_tab[k] - 1));
            send_name();
        end
    endtask

    task automatic test_backpressure();
        set_limits(6'd2, 8'd16);
        tx_gaps = 1'b0;
        rx_mode <= RX_HOLD;
        repeat (20) begin
            make_name();
            send_name();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_label_faults();
        test_random_names();
        test_long_names();
        test_backpressure();
        drain();
        $display("Checked %0d verdicts for %0d names (%0d bytes)", verdicts_seen, names_sent,
                 bytes_sent);
        $display("Covered %0d length settings, long saturating names and output hold-off",
                 settings_used);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
